>>> src/spkr_pkg.sv
`timescale 1ns / 1ps
package spkr_pkg;

    localparam int LANES = 8;

    typedef logic [LANES-1:0][31:0] t_frame;

    typedef enum logic [3:0] {
        G_NONE,
        G_ONE,
        G_HALF,
        G_QUARTER,
        G_EIGHTH,
        G_FIFTH,
        G_P33,
        G_P66,
        G_SEVENTH
    } t_gain;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic       ok;
        logic [3:0] il;
        logic [3:0] ol;
    } t_ctrl;

    // Outer key is {input layout, output layout} as two hex digits,
    // inner key is {source lane, destination lane} as two octal digits.
    function automatic t_gain gain_code(logic [3:0] il, logic [3:0] ol,
                                        logic [2:0] s, logic [2:0] d);
        t_gain g;
        g = G_NONE;
        if (il == 4'd1) begin
            g = (s == 3'd0) ? G_ONE : G_NONE;
        end else if (il == ol) begin
            g = (s == d) ? G_ONE : G_NONE;
        end else begin
            case ({il, ol})
                8'h21: case ({s, d})
                    6'o00, 6'o10: g = G_HALF;
                    default: g = G_NONE;
                endcase
                8'h24: case ({s, d})
                    6'o00, 6'o11, 6'o02, 6'o13: g = G_ONE;
                    default: g = G_NONE;
                endcase
                8'h26: case ({s, d})
                    6'o00, 6'o11, 6'o04, 6'o15: g = G_ONE;
                    6'o02, 6'o12, 6'o03, 6'o13: g = G_HALF;
                    default: g = G_NONE;
                endcase
                8'h28: case ({s, d})
                    6'o00, 6'o06, 6'o04, 6'o11, 6'o17, 6'o15: g = G_ONE;
                    6'o02, 6'o12, 6'o03, 6'o13: g = G_HALF;
                    default: g = G_NONE;
                endcase
                8'h41: case ({s, d})
                    6'o00, 6'o10, 6'o20, 6'o30: g = G_QUARTER;
                    default: g = G_NONE;
                endcase
                8'h42: case ({s, d})
                    6'o00, 6'o11, 6'o20, 6'o31: g = G_HALF;
                    default: g = G_NONE;
                endcase
                8'h46: case ({s, d})
                    6'o00, 6'o11, 6'o24, 6'o35: g = G_ONE;
                    6'o02, 6'o12: g = G_HALF;
                    6'o03, 6'o13, 6'o23, 6'o33: g = G_QUARTER;
                    default: g = G_NONE;
                endcase
                8'h48: case ({s, d})
                    6'o00, 6'o11, 6'o24, 6'o35: g = G_ONE;
                    6'o02, 6'o12, 6'o06, 6'o17, 6'o26, 6'o37: g = G_HALF;
                    6'o03, 6'o13, 6'o23, 6'o33: g = G_QUARTER;
                    default: g = G_NONE;
                endcase
                8'h61: case ({s, d})
                    6'o00, 6'o10, 6'o20, 6'o40, 6'o50: g = G_FIFTH;
                    default: g = G_NONE;
                endcase
                8'h62: case ({s, d})
                    6'o00, 6'o11, 6'o20, 6'o21, 6'o40, 6'o51: g = G_P33;
                    default: g = G_NONE;
                endcase
                8'h64: case ({s, d})
                    6'o00, 6'o11: g = G_P66;
                    6'o20, 6'o21: g = G_P33;
                    6'o42, 6'o53: g = G_ONE;
                    default: g = G_NONE;
                endcase
                8'h68: case ({s, d})
                    6'o00, 6'o11, 6'o22, 6'o33, 6'o44, 6'o55: g = G_ONE;
                    6'o06, 6'o17, 6'o46, 6'o57: g = G_HALF;
                    default: g = G_NONE;
                endcase
                8'h81: case ({s, d})
                    6'o00, 6'o10, 6'o20, 6'o40, 6'o50, 6'o60, 6'o70: g = G_SEVENTH;
                    default: g = G_NONE;
                endcase
                8'h82: case ({s, d})
                    6'o00, 6'o11: g = G_HALF;
                    6'o20, 6'o21: g = G_QUARTER;
                    6'o40, 6'o51, 6'o60, 6'o71: g = G_EIGHTH;
                    default: g = G_NONE;
                endcase
                8'h84: case ({s, d})
                    6'o00, 6'o11: g = G_HALF;
                    6'o20, 6'o21, 6'o60, 6'o71: g = G_QUARTER;
                    6'o42, 6'o53: g = G_P66;
                    6'o62, 6'o73: g = G_P33;
                    default: g = G_NONE;
                endcase
                8'h86: case ({s, d})
                    6'o00, 6'o11, 6'o44, 6'o55: g = G_P66;
                    6'o22, 6'o33: g = G_ONE;
                    6'o60, 6'o71, 6'o64, 6'o75: g = G_P33;
                    default: g = G_NONE;
                endcase
                default: g = G_NONE;
            endcase
        end
        return g;
    endfunction

endpackage

>>> src/speaker_layout_remix_matrix.sv
`timescale 1ns / 1ps
// Speaker layout remix matrix: remaps one frame of up to eight 32-bit
// samples from the input layout to the output layout (1, 2, 4, 6 or 8 ch).
//
// Frame in: sample ports plus i_frame_last, taken at a clock edge with
// start high and busy low. busy is high only while reset is asserted, so a
// new frame can be started every cycle.
// Result out: o_mixed_* and o_result_last, valid for the one cycle that
// o_done is high. The receiver cannot stall; nothing is buffered.
// Pipeline: start to o_done runs through one registered mixing cell per
// input lane, then the registered rounding/saturation stage.
// Throughput: one frame per cycle.
// Layouts: APB registers 0x0 (input channels) and 0x4 (output channels),
// both 2 after reset. Change them only while no frame is in flight.
// Reset (synchronous) empties the pipeline; frames in flight are dropped.
module speaker_layout_remix_matrix import spkr_pkg::*; #(
    parameter int CHANNEL_COUNT      = 8,
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_sample_0,
    input  logic signed [31:0] i_sample_1,
    input  logic signed [31:0] i_sample_2,
    input  logic signed [31:0] i_sample_3,
    input  logic signed [31:0] i_sample_4,
    input  logic signed [31:0] i_sample_5,
    input  logic signed [31:0] i_sample_6,
    input  logic signed [31:0] i_sample_7,
    input  logic               i_frame_last,
    output logic               o_done,
    output logic signed [31:0] o_mixed_0,
    output logic signed [31:0] o_mixed_1,
    output logic signed [31:0] o_mixed_2,
    output logic signed [31:0] o_mixed_3,
    output logic signed [31:0] o_mixed_4,
    output logic signed [31:0] o_mixed_5,
    output logic signed [31:0] o_mixed_6,
    output logic signed [31:0] o_mixed_7,
    output logic               o_result_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int   ACC_W          = GAIN_FRACTION_BITS + 37;
    localparam logic REG_IN_LAYOUT  = 1'b0;
    localparam logic REG_OUT_LAYOUT = 1'b1;

    logic [3:0] r_il;
    logic [3:0] r_ol;
    logic       w_wr;
    logic       w_ok;
    t_ctrl      w_ctrl_in;
    t_frame     w_frame_in;
    t_frame     w_mixed;

    t_ctrl                       w_ctrl  [CHANNEL_COUNT+1];
    t_frame                      w_frame [CHANNEL_COUNT+1];
    logic [LANES-1:0][ACC_W-1:0] w_acc   [CHANNEL_COUNT+1];

    // configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_il <= 4'd2;
            r_ol <= 4'd2;
        end else if (w_wr) begin
            case (paddr[2])
                REG_IN_LAYOUT:  r_il <= pwdata[3:0];
                REG_OUT_LAYOUT: r_ol <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IN_LAYOUT:  prdata = {28'd0, r_il};
            REG_OUT_LAYOUT: prdata = {28'd0, r_ol};
            default:        prdata = '0;
        endcase
    end

    // layout pair check; mono input fans out to any output count
    always_comb begin
        w_ok = (r_il >= 4'd1) && (r_il <= 4'(CHANNEL_COUNT)) &&
               (r_ol >= 4'd1) && (r_ol <= 4'(CHANNEL_COUNT)) &&
               (r_il inside {4'd1, 4'd2, 4'd4, 4'd6, 4'd8}) &&
               ((r_il == 4'd1) || (r_ol inside {4'd1, 4'd2, 4'd4, 4'd6, 4'd8}));
    end

    assign busy = !i_rst_n;

    assign w_ctrl_in.valid = start && !busy;
    assign w_ctrl_in.last  = i_frame_last;
    assign w_ctrl_in.ok    = w_ok;
    assign w_ctrl_in.il    = r_il;
    assign w_ctrl_in.ol    = r_ol;

    assign w_frame_in = {i_sample_7, i_sample_6, i_sample_5, i_sample_4,
                         i_sample_3, i_sample_2, i_sample_1, i_sample_0};

    assign w_ctrl[0]  = w_ctrl_in;
    assign w_frame[0] = w_frame_in;
    assign w_acc[0]   = '0;

    for (genvar s = 0; s < CHANNEL_COUNT; s++) begin : g_cell
        spkr_mix_cell #(
            .LANE              (s),
            .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (w_ctrl[s]),
            .i_frame(w_frame[s]),
            .i_acc  (w_acc[s]),
            .o_ctrl (w_ctrl[s+1]),
            .o_frame(w_frame[s+1]),
            .o_acc  (w_acc[s+1])
        );
    end

    spkr_out_stage #(
        .CHANNEL_COUNT     (CHANNEL_COUNT),
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl[CHANNEL_COUNT]),
        .i_acc  (w_acc[CHANNEL_COUNT]),
        .o_done (o_done),
        .o_last (o_result_last),
        .o_mixed(w_mixed)
    );

    assign o_mixed_0 = w_mixed[0];
    assign o_mixed_1 = w_mixed[1];
    assign o_mixed_2 = w_mixed[2];
    assign o_mixed_3 = w_mixed[3];
    assign o_mixed_4 = w_mixed[4];
    assign o_mixed_5 = w_mixed[5];
    assign o_mixed_6 = w_mixed[6];
    assign o_mixed_7 = w_mixed[7];

endmodule

>>> src/spkr_mix_cell.sv
`timescale 1ns / 1ps
// One input lane of the mixing chain: adds this lane's weighted sample into
// all eight running sums if il > LANE; hands the frame on to the next cell.
module spkr_mix_cell import spkr_pkg::*; #(
    parameter int LANE               = 0,
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl                   i_ctrl,
    input  t_frame                  i_frame,
    input  logic [LANES-1:0][GAIN_FRACTION_BITS+36:0] i_acc,
    output t_ctrl                   o_ctrl,
    output t_frame                  o_frame,
    output logic [LANES-1:0][GAIN_FRACTION_BITS+36:0] o_acc
);

    localparam int F      = GAIN_FRACTION_BITS;
    localparam int ACC_W  = F + 37;
    localparam int GW     = F + 1;
    localparam int PW     = F + 34;

    // Gains rounded to nearest, halves up
    localparam logic [GW-1:0] GX_ONE     = GW'(2 ** F);
    localparam logic [GW-1:0] GX_HALF    = GW'((2 ** F + 1) / 2);
    localparam logic [GW-1:0] GX_QUARTER = GW'((2 ** F + 2) / 4);
    localparam logic [GW-1:0] GX_EIGHTH  = GW'((2 ** F + 4) / 8);
    localparam logic [GW-1:0] GX_FIFTH   = GW'((2 ** F + 2) / 5);
    localparam logic [GW-1:0] GX_P33     = GW'((33 * 2 ** F + 50) / 100);
    localparam logic [GW-1:0] GX_P66     = GW'((66 * 2 ** F + 50) / 100);
    localparam logic [GW-1:0] GX_SEVENTH = GW'((2 ** F + 3) / 7);

    function automatic logic [GW-1:0] gain_fx(t_gain c);
        logic [GW-1:0] v;
        case (c)
            G_ONE:     v = GX_ONE;
            G_HALF:    v = GX_HALF;
            G_QUARTER: v = GX_QUARTER;
            G_EIGHTH:  v = GX_EIGHTH;
            G_FIFTH:   v = GX_FIFTH;
            G_P33:     v = GX_P33;
            G_P66:     v = GX_P66;
            G_SEVENTH: v = GX_SEVENTH;
            default:   v = '0;
        endcase
        return v;
    endfunction

    logic                          w_use;
    logic [LANES-1:0][ACC_W-1:0]   n_acc;
    t_ctrl                         r_ctrl;
    t_frame                        r_frame;
    logic [LANES-1:0][ACC_W-1:0]   r_acc;

    assign w_use = i_ctrl.il > 4'(LANE);

    for (genvar d = 0; d < LANES; d++) begin : g_dst
        logic [GW-1:0]        w_gain;
        logic signed [PW-1:0] w_prod;

        assign w_gain = gain_fx(gain_code(i_ctrl.il, i_ctrl.ol, 3'(LANE), 3'(d)));
        assign w_prod = $signed(i_frame[LANE]) * $signed({1'b0, w_gain});

        always_comb begin
            n_acc[d] = i_acc[d];
            if (w_use) begin
                n_acc[d] = i_acc[d] + {{(ACC_W-PW){w_prod[PW-1]}}, w_prod};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else begin
            r_ctrl.valid <= i_ctrl.valid;
        end
        r_ctrl.last <= i_ctrl.last;
        r_ctrl.ok   <= i_ctrl.ok;
        r_ctrl.il   <= i_ctrl.il;
        r_ctrl.ol   <= i_ctrl.ol;
        r_frame     <= i_frame;
        r_acc       <= n_acc;
    end

    assign o_ctrl  = r_ctrl;
    assign o_frame = r_frame;
    assign o_acc   = r_acc;

endmodule

>>> src/spkr_out_stage.sv
`timescale 1ns / 1ps
// Scales the sums back down (toward zero), saturates to 32 bits and masks
// lanes outside the output layout, or all lanes for an unsupported pair.
module spkr_out_stage import spkr_pkg::*; #(
    parameter int CHANNEL_COUNT      = 8,
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl                   i_ctrl,
    input  logic [LANES-1:0][GAIN_FRACTION_BITS+36:0] i_acc,
    output logic                    o_done,
    output logic                    o_last,
    output t_frame                  o_mixed
);

    localparam int F     = GAIN_FRACTION_BITS;
    localparam int ACC_W = F + 37;
    localparam int QW    = ACC_W - F;

    t_frame n_mixed;
    t_frame r_mixed;
    logic   r_done;
    logic   r_last;

    for (genvar d = 0; d < LANES; d++) begin : g_lane
        logic signed [ACC_W-1:0] w_acc;
        logic signed [QW-1:0]    w_q;
        logic                    w_fits;
        logic                    w_live;

        assign w_acc  = $signed(i_acc[d]);
        // arithmetic shift floors, so bump negatives with a dropped fraction
        assign w_q    = QW'(w_acc >>> F) + QW'(w_acc[ACC_W-1] && (|w_acc[F-1:0]));
        assign w_fits = (w_q[QW-1:31] == '0) || (w_q[QW-1:31] == '1);
        assign w_live = i_ctrl.ok && (i_ctrl.ol > 4'(d)) && (d < CHANNEL_COUNT);

        always_comb begin
            if (!w_live) begin
                n_mixed[d] = '0;
            end else if (w_fits) begin
                n_mixed[d] = w_q[31:0];
            end else if (w_q[QW-1]) begin
                n_mixed[d] = 32'h8000_0000;
            end else begin
                n_mixed[d] = 32'h7fff_ffff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= i_ctrl.last;
        r_mixed <= n_mixed;
    end

    assign o_done  = r_done;
    assign o_last  = r_last;
    assign o_mixed = r_mixed;

endmodule

>>> src/spkr_chk.sv
`timescale 1ns / 1ps
module spkr_chk #(
    parameter int CHANNEL_COUNT = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        pready,
    input logic [31:0] o_mixed_0,
    input logic [31:0] o_mixed_1,
    input logic [31:0] o_mixed_2,
    input logic [31:0] o_mixed_3,
    input logic [31:0] o_mixed_4,
    input logic [31:0] o_mixed_5,
    input logic [31:0] o_mixed_6,
    input logic [31:0] o_mixed_7
);

    localparam int LAT = CHANNEL_COUNT + 1;

    logic [7:0][31:0] w_mixed;

    assign w_mixed = {o_mixed_7, o_mixed_6, o_mixed_5, o_mixed_4,
                      o_mixed_3, o_mixed_2, o_mixed_1, o_mixed_0};

    a_done_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("transfer in without result after fixed latency");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result with no matching transfer in");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    for (genvar d = CHANNEL_COUNT; d < 8; d++) begin : g_unused
        a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            o_done |-> (w_mixed[d] == 32'd0))
            else $error("lane beyond channel count not zero");
    end

endmodule

bind speaker_layout_remix_matrix spkr_chk #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_spkr_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .pready   (pready),
    .o_mixed_0(o_mixed_0),
    .o_mixed_1(o_mixed_1),
    .o_mixed_2(o_mixed_2),
    .o_mixed_3(o_mixed_3),
    .o_mixed_4(o_mixed_4),
    .o_mixed_5(o_mixed_5),
    .o_mixed_6(o_mixed_6),
    .o_mixed_7(o_mixed_7)
);

>>> tb/sv/speaker_layout_remix_matrix_tb.sv
`timescale 1ns / 1ps
module speaker_layout_remix_matrix_tb import spkr_pkg::*;;

    localparam int GAIN_FRAC = 16;
    localparam int LATENCY = 9;
    localparam int LIMIT = 200000;
    localparam int RANDOM_FRAMES = 2000;
    localparam logic [2:0] REG_IN_LAYOUT = 3'h0;
    localparam logic [2:0] REG_OUT_LAYOUT = 3'h4;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]  il;
        logic [3:0]  ol;
        logic [31:0] even;
        logic [31:0] odd;
        logic        last;
        logic        typed;
        logic [31:0] want_even;
        logic [31:0] want_odd;
        logic [3:0]  want_lanes;
    } t_row;

    typedef struct {
        t_frame mixed;
        logic   last;
    } t_mix;

    // typed rows carry their result; the rest go through remix_frame
    localparam int N_DIR = 28;
    localparam t_row PLAN [N_DIR] = '{
        '{4'd2, 4'd2, MAXV, MINV, 1'b1, 1'b1, MAXV, MINV, 4'd2},
        '{4'd8, 4'd8, MAXV, MINV, 1'b1, 1'b1, MAXV, MINV, 4'd8},
        '{4'd6, 4'd6, MINV, MAXV, 1'b0, 1'b1, MINV, MAXV, 4'd6},
        '{4'd4, 4'd4, MAXV, MINV, 1'b1, 1'b1, MAXV, MINV, 4'd4},
        '{4'd1, 4'd1, MINV, MAXV, 1'b0, 1'b1, MINV, MINV, 4'd1},
        '{4'd1, 4'd8, MINV, MAXV, 1'b1, 1'b1, MINV, MINV, 4'd8},
        '{4'd1, 4'd5, MAXV, MINV, 1'b0, 1'b1, MAXV, MAXV, 4'd5},
        '{4'd3, 4'd4, MAXV, MAXV, 1'b1, 1'b1, 32'd0, 32'd0, 4'd0},
        '{4'd2, 4'd3, MAXV, MINV, 1'b1, 1'b1, 32'd0, 32'd0, 4'd0},
        '{4'd0, 4'd8, MAXV, MINV, 1'b0, 1'b1, 32'd0, 32'd0, 4'd0},
        '{4'd8, 4'd9, MINV, MINV, 1'b1, 1'b1, 32'd0, 32'd0, 4'd0},
        '{4'd15, 4'd15, MAXV, MAXV, 1'b1, 1'b1, 32'd0, 32'd0, 4'd0},
        '{4'd2, 4'd1, MAXV, MAXV, 1'b0, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd2, 4'd4, MINV, MAXV, 1'b1, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd2, 4'd6, MAXV, MAXV, 1'b0, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd2, 4'd8, MINV, MINV, 1'b1, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd4, 4'd1, MAXV, MAXV, 1'b0, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd4, 4'd2, MINV, MINV, 1'b1, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd4, 4'd6, MAXV, MINV, 1'b0, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd4, 4'd8, MINV, MINV, 1'b1, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd6, 4'd1, MAXV, MAXV, 1'b0, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd6, 4'd2, MINV, MINV, 1'b1, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd6, 4'd4, MAXV, MAXV, 1'b0, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd6, 4'd8, MINV, MAXV, 1'b1, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd8, 4'd1, MAXV, MAXV, 1'b0, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd8, 4'd2, MINV, MINV, 1'b1, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd8, 4'd4, MAXV, MAXV, 1'b0, 1'b0, 32'd0, 32'd0, 4'd0},
        '{4'd8, 4'd6, MINV, MINV, 1'b1, 1'b0, 32'd0, 32'd0, 4'd0}
    };

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_sample_0 = '0;
    logic [31:0] i_sample_1 = '0;
    logic [31:0] i_sample_2 = '0;
    logic [31:0] i_sample_3 = '0;
    logic [31:0] i_sample_4 = '0;
    logic [31:0] i_sample_5 = '0;
    logic [31:0] i_sample_6 = '0;
    logic [31:0] i_sample_7 = '0;
    logic        i_frame_last = 1'b0;
    logic        o_done;
    logic [31:0] o_mixed_0, o_mixed_1, o_mixed_2, o_mixed_3;
    logic [31:0] o_mixed_4, o_mixed_5, o_mixed_6, o_mixed_7;
    logic        o_result_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    speaker_layout_remix_matrix dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_sample_0    (i_sample_0),
        .i_sample_1    (i_sample_1),
        .i_sample_2    (i_sample_2),
        .i_sample_3    (i_sample_3),
        .i_sample_4    (i_sample_4),
        .i_sample_5    (i_sample_5),
        .i_sample_6    (i_sample_6),
        .i_sample_7    (i_sample_7),
        .i_frame_last  (i_frame_last),
        .o_done        (o_done),
        .o_mixed_0     (o_mixed_0),
        .o_mixed_1     (o_mixed_1),
        .o_mixed_2     (o_mixed_2),
        .o_mixed_3     (o_mixed_3),
        .o_mixed_4     (o_mixed_4),
        .o_mixed_5     (o_mixed_5),
        .o_mixed_6     (o_mixed_6),
        .o_mixed_7     (o_mixed_7),
        .o_result_last (o_result_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    t_gain       mix_gain [0:15][0:15][0:7][0:7];
    t_mix        pending_mix [$];
    logic [3:0]  cur_il = 4'd2;
    logic [3:0]  cur_ol = 4'd2;
    int          n_err = 0;
    int          n_checked = 0;
    int          n_layouts = 0;
    int          cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic put(int il, int ol, int s, int d, t_gain g);
        mix_gain[il][ol][s][d] = g;
    endtask

    function automatic bit layout_ok(logic [3:0] n);
        case (n)
            4'd1, 4'd2, 4'd4, 4'd6, 4'd8: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // rounded Q16 weight of a gain code
    function automatic longint gain_weight(t_gain g);
        longint num;
        longint den;
        case (g)
            G_ONE:     begin num = 1;  den = 1;   end
            G_HALF:    begin num = 1;  den = 2;   end
            G_QUARTER: begin num = 1;  den = 4;   end
            G_EIGHTH:  begin num = 1;  den = 8;   end
            G_FIFTH:   begin num = 1;  den = 5;   end
            G_P33:     begin num = 33; den = 100; end
            G_P66:     begin num = 66; den = 100; end
            G_SEVENTH: begin num = 1;  den = 7;   end
            default:   begin num = 0;  den = 1;   end
        endcase
        return ((num << GAIN_FRAC) + den / 2) / den;
    endfunction

    function automatic t_mix remix_frame(t_frame smp, logic last, logic [3:0] il,
                                         logic [3:0] ol);
        t_mix   r;
        bit     ok;
        t_gain  g;
        longint acc;
        longint q;
        ok = layout_ok(il) && ol >= 4'd1 && ol <= 4'd8 && (il == 4'd1 || layout_ok(ol));
        for (int d = 0; d < 8; d++) begin
            acc = 0;
            if (ok && d < ol) begin
                for (int s = 0; s < il; s++) begin
                    if (il == 4'd1)
                        g = (s == 0) ? G_ONE : G_NONE;
                    else if (il == ol)
                        g = (s == d) ? G_ONE : G_NONE;
                    else
                        g = mix_gain[il][ol][s][d];
                    acc += longint'(signed'(smp[s])) * gain_weight(g);
                end
            end
            q = acc / (longint'(1) << GAIN_FRAC);   // truncates toward zero
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            if (q < -64'sd2147483648)
                q = -64'sd2147483648;
            r.mixed[d] = q[31:0];
        end
        r.last = last;
        return r;
    endfunction

    function automatic logic [31:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return MAXV;
            1: return MINV;
            2: return 32'd0;
            3: return 32'hffff_ffff;
            4: return 32'(signed'($urandom_range(0, 511)) - 256);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] draw_layout();
        case ($urandom_range(0, 4))
            0: return 4'd1;
            1: return 4'd2;
            2: return 4'd4;
            3: return 4'd6;
            default: return 4'd8;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_mix   want;
        t_frame got;
        if (i_rst_n && o_done === 1'b1) begin
            got = {o_mixed_7, o_mixed_6, o_mixed_5, o_mixed_4,
                   o_mixed_3, o_mixed_2, o_mixed_1, o_mixed_0};
            if (pending_mix.size() == 0) begin
                $error("result with no frame pending");
                n_err++;
            end else begin
                want = pending_mix.pop_front();
                for (int d = 0; d < 8; d++) begin
                    if (got[d] !== want.mixed[d]) begin
                        $error("mixed_%0d: expected %0d, got %0d", d,
                               signed'(want.mixed[d]), signed'(got[d]));
                        n_err++;
                    end
                end
                if (o_result_last !== want.last) begin
                    $error("result_last: expected %0b, got %0b", want.last, o_result_last);
                    n_err++;
                end
                n_checked++;
            end
        end
    end

    // write, then read back over the same select
    task automatic write_reg(logic [2:0] addr, logic [3:0] v);
        logic [31:0] word;
        word = $urandom;
        word[3:0] = v;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == REG_IN_LAYOUT)
            cur_il = v;
        else
            cur_ol = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {28'd0, v}) begin
            $error("prdata at %0h: expected %0h, got %0h", addr, {28'd0, v}, prdata);
            n_err++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_layouts(logic [3:0] il, logic [3:0] ol);
        drain();
        write_reg(REG_IN_LAYOUT, il);
        write_reg(REG_OUT_LAYOUT, ol);
        n_layouts++;
    endtask

    task automatic send_frame(t_frame smp, logic last, t_mix want);
        i_sample_0 <= smp[0];
        i_sample_1 <= smp[1];
        i_sample_2 <= smp[2];
        i_sample_3 <= smp[3];
        i_sample_4 <= smp[4];
        i_sample_5 <= smp[5];
        i_sample_6 <= smp[6];
        i_sample_7 <= smp[7];
        i_frame_last <= last;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_mix.push_back(want);
    endtask

    task automatic maybe_idle(bit quiet);
        if (!quiet && $urandom_range(0, 99) < 15) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    initial begin
        t_frame smp;
        t_mix   want;
        logic   last;
        int     n_rand;
        int     run;

        for (int a = 0; a < 16; a++)
            for (int b = 0; b < 16; b++)
                for (int s = 0; s < 8; s++)
                    for (int d = 0; d < 8; d++)
                        mix_gain[a][b][s][d] = G_NONE;
        put(2,1,0,0,G_HALF); put(2,1,1,0,G_HALF);
        put(2,4,0,0,G_ONE); put(2,4,1,1,G_ONE); put(2,4,0,2,G_ONE); put(2,4,1,3,G_ONE);
        put(2,6,0,0,G_ONE); put(2,6,1,1,G_ONE); put(2,6,0,4,G_ONE); put(2,6,1,5,G_ONE);
        put(2,6,0,2,G_HALF); put(2,6,1,2,G_HALF); put(2,6,0,3,G_HALF); put(2,6,1,3,G_HALF);
        put(2,8,0,0,G_ONE); put(2,8,0,6,G_ONE); put(2,8,0,4,G_ONE); put(2,8,1,1,G_ONE);
        put(2,8,1,7,G_ONE); put(2,8,1,5,G_ONE); put(2,8,0,2,G_HALF); put(2,8,1,2,G_HALF);
        put(2,8,0,3,G_HALF); put(2,8,1,3,G_HALF);
        put(4,1,0,0,G_QUARTER); put(4,1,1,0,G_QUARTER);
        put(4,1,2,0,G_QUARTER); put(4,1,3,0,G_QUARTER);
        put(4,2,0,0,G_HALF); put(4,2,1,1,G_HALF); put(4,2,2,0,G_HALF); put(4,2,3,1,G_HALF);
        put(4,6,0,0,G_ONE); put(4,6,1,1,G_ONE); put(4,6,0,2,G_HALF); put(4,6,1,2,G_HALF);
        put(4,6,0,3,G_QUARTER); put(4,6,1,3,G_QUARTER);
        put(4,6,2,3,G_QUARTER); put(4,6,3,3,G_QUARTER);
        put(4,6,2,4,G_ONE); put(4,6,3,5,G_ONE);
        put(4,8,0,0,G_ONE); put(4,8,1,1,G_ONE); put(4,8,0,2,G_HALF); put(4,8,1,2,G_HALF);
        put(4,8,0,3,G_QUARTER); put(4,8,1,3,G_QUARTER);
        put(4,8,2,3,G_QUARTER); put(4,8,3,3,G_QUARTER);
        put(4,8,2,4,G_ONE); put(4,8,3,5,G_ONE); put(4,8,0,6,G_HALF); put(4,8,1,7,G_HALF);
        put(4,8,2,6,G_HALF); put(4,8,3,7,G_HALF);
        put(6,1,0,0,G_FIFTH); put(6,1,1,0,G_FIFTH); put(6,1,2,0,G_FIFTH);
        put(6,1,4,0,G_FIFTH); put(6,1,5,0,G_FIFTH);
        put(6,2,0,0,G_P33); put(6,2,1,1,G_P33); put(6,2,2,0,G_P33);
        put(6,2,2,1,G_P33); put(6,2,4,0,G_P33); put(6,2,5,1,G_P33);
        put(6,4,0,0,G_P66); put(6,4,1,1,G_P66); put(6,4,2,0,G_P33);
        put(6,4,2,1,G_P33); put(6,4,4,2,G_ONE); put(6,4,5,3,G_ONE);
        put(6,8,0,0,G_ONE); put(6,8,1,1,G_ONE); put(6,8,2,2,G_ONE); put(6,8,3,3,G_ONE);
        put(6,8,4,4,G_ONE); put(6,8,5,5,G_ONE); put(6,8,0,6,G_HALF); put(6,8,1,7,G_HALF);
        put(6,8,4,6,G_HALF); put(6,8,5,7,G_HALF);
        put(8,1,0,0,G_SEVENTH); put(8,1,1,0,G_SEVENTH); put(8,1,2,0,G_SEVENTH);
        put(8,1,4,0,G_SEVENTH); put(8,1,5,0,G_SEVENTH); put(8,1,6,0,G_SEVENTH);
        put(8,1,7,0,G_SEVENTH);
        put(8,2,0,0,G_HALF); put(8,2,1,1,G_HALF); put(8,2,2,0,G_QUARTER);
        put(8,2,2,1,G_QUARTER); put(8,2,4,0,G_EIGHTH); put(8,2,5,1,G_EIGHTH);
        put(8,2,6,0,G_EIGHTH); put(8,2,7,1,G_EIGHTH);
        put(8,4,0,0,G_HALF); put(8,4,1,1,G_HALF); put(8,4,2,0,G_QUARTER);
        put(8,4,2,1,G_QUARTER); put(8,4,4,2,G_P66); put(8,4,5,3,G_P66);
        put(8,4,6,0,G_QUARTER); put(8,4,7,1,G_QUARTER); put(8,4,6,2,G_P33);
        put(8,4,7,3,G_P33);
        put(8,6,0,0,G_P66); put(8,6,1,1,G_P66); put(8,6,2,2,G_ONE); put(8,6,3,3,G_ONE);
        put(8,6,4,4,G_P66); put(8,6,5,5,G_P66); put(8,6,6,0,G_P33); put(8,6,7,1,G_P33);
        put(8,6,6,4,G_P33); put(8,6,7,5,G_P33);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: layouts start at their reset value of 2 / 2
        for (int i = 0; i < N_DIR; i++) begin
            if (PLAN[i].il != cur_il || PLAN[i].ol != cur_ol)
                set_layouts(PLAN[i].il, PLAN[i].ol);
            for (int d = 0; d < 8; d++)
                smp[d] = d[0] ? PLAN[i].odd : PLAN[i].even;
            if (PLAN[i].typed) begin
                for (int d = 0; d < 8; d++)
                    want.mixed[d] = (d < PLAN[i].want_lanes) ?
                                    (d[0] ? PLAN[i].want_odd : PLAN[i].want_even) : 32'd0;
                want.last = PLAN[i].last;
            end else begin
                want = remix_frame(smp, PLAN[i].last, cur_il, cur_ol);
            end
            maybe_idle(1'b0);
            send_frame(smp, PLAN[i].last, want);
        end

        // random: phases of one layout pair each, drained before every change
        n_rand = 0;
        while (n_rand < RANDOM_FRAMES) begin
            if ($urandom_range(0, 9) < 8) begin
                smp[0][3:0] = draw_layout();
                smp[1][3:0] = (smp[0][3:0] == 4'd1) ? 4'($urandom_range(1, 8)) : draw_layout();
            end else begin
                smp[0][3:0] = 4'($urandom_range(0, 15));
                smp[1][3:0] = 4'($urandom_range(0, 15));
            end
            set_layouts(smp[0][3:0], smp[1][3:0]);
            run = $urandom_range(10, 120);
            for (int k = 0; k < run && n_rand < RANDOM_FRAMES; k++) begin
                for (int d = 0; d < 8; d++)
                    smp[d] = draw_sample();
                last = 1'($urandom);
                want = remix_frame(smp, last, cur_il, cur_ol);
                // back-to-back stretch for random frames 700 to 1099
                maybe_idle(n_rand >= 700 && n_rand < 1100);
                send_frame(smp, last, want);
                n_rand++;
            end
        end

        drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("%0d frames checked: %0d directed, %0d random, over %0d layout settings",
                 n_checked, N_DIR, n_rand, n_layouts);
        $display("covered mono, passthrough, every mixing pair and unsupported layouts");
        if (n_err == 0 && pending_mix.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
